[rtl/core/sos_pkg.sv]
// Shared types and constants for the separator splitter.
`default_nettype none

package sos_pkg;

    // Character width and the widest separator the sep_chars register can hold
    localparam int CHAR_W  = 16;
    localparam int SEP_CAP = 4;

    // Result requests produced by one input request, at most
    localparam int PUSH_MAX = 3;

    // Result queue depth and the fill level up to which new requests are taken
    localparam int QUEUE_DEPTH  = 8;
    localparam int ACCEPT_LEVEL = QUEUE_DEPTH - 2 * PUSH_MAX;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SEP_LEN   = 1'b0,
        REG_SEP_CHARS = 1'b1
    } cfg_reg_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SEG     = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_NOSPLIT = 2'd2,
        KIND_TOOLONG = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  start;
        logic [CHAR_W-1:0]  length;
        logic               last;
    } result_t;

    // Results from one request, in order, written into the queue together
    typedef struct packed {
        logic [1:0]                 count;
        result_t [PUSH_MAX-1:0]     items;
    } push_t;

endpackage

`default_nettype wire

[rtl/core/sos_core.sv]
// Input register, split state and result generation for one request per cycle.
`default_nettype none

module sos_core #(
    parameter int MAX_SEP = 4,
    parameter int MAX_LEN = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [sos_pkg::CHAR_W-1:0]    ch,
    input  wire logic                          has_char,
    input  wire logic                          end_of_string,
    input  wire logic [2:0]                    sep_len,
    input  wire logic [4*sos_pkg::CHAR_W-1:0]  sep_chars,
    output sos_pkg::push_t                     push
);

    localparam int WIN = (MAX_SEP < sos_pkg::SEP_CAP) ? MAX_SEP : sos_pkg::SEP_CAP;
    localparam int PW  = $clog2(MAX_LEN + 2);
    localparam logic [PW-1:0] LEN_LIMIT   = PW'(MAX_LEN);
    localparam logic [PW-1:0] TOO_LONG_PS = PW'(MAX_LEN + 1);
    localparam logic [2:0]    WIN_LEN     = 3'(WIN);

    typedef logic [sos_pkg::CHAR_W-1:0] char_t;

    // Registered request
    logic  item_valid_reg;
    char_t ch_reg;
    logic  has_reg;
    logic  eos_reg;

    // Split state
    char_t [WIN-1:0] window_reg,     window_next;
    logic [2:0]      csm_reg,        csm_next;
    logic [PW-1:0]   pos_reg,        pos_next;
    char_t           open_start_reg, open_start_next;
    logic            seg_open_reg,   seg_open_next;
    logic [1:0]      count_reg,      count_next;
    char_t           held_len_reg,   held_len_next;
    logic            held_valid_reg, held_valid_next;

    logic [2:0]      eff_len;
    char_t [WIN-1:0] win_shift;
    logic            win_match;
    char_t           match_len;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch;
            has_reg <= has_char;
            eos_reg <= end_of_string;
        end
    end

    // Effective separator length: zero acts as one, clipped to the window
    always_comb
    begin
        if (sep_len == 3'd0)
            eff_len = 3'd1;
        else if (sep_len > WIN_LEN)
            eff_len = WIN_LEN;
        else
            eff_len = sep_len;
    end

    // Window with the new character shifted in, compared against the separator
    always_comb
    begin
        logic [1:0] sel;
        sel = 2'd0;
        win_shift[0] = ch_reg;
        for (int k = 1; k < WIN; k++)
            win_shift[k] = window_reg[k-1];
        win_match = 1'b1;
        for (int k = 0; k < WIN; k++)
        begin
            // newest character meets the separator's last character
            sel = 2'(eff_len - 3'd1 - 3'(k));
            if (3'(k) < eff_len && win_shift[k] != sep_chars[{sel, 4'b0000} +: sos_pkg::CHAR_W])
                win_match = 1'b0;
        end
    end

    // Next state and results
    always_comb
    begin
        window_next     = window_reg;
        csm_next        = csm_reg;
        pos_next        = pos_reg;
        open_start_next = open_start_reg;
        seg_open_next   = seg_open_reg;
        count_next      = count_reg;
        held_len_next   = held_len_reg;
        held_valid_next = held_valid_reg;
        match_len       = '0;
        push            = '0;

        if (item_valid_reg)
        begin
            if (has_reg && pos_reg >= LEN_LIMIT)
            begin
                // overlong: character dropped, string marked
                pos_next = TOO_LONG_PS;
            end
            else if (has_reg)
            begin
                window_next = win_shift;
                if (csm_reg != 3'd7)
                    csm_next = csm_reg + 3'd1;

                // first character of a string or after a match opens a segment
                if (!seg_open_reg)
                begin
                    seg_open_next   = 1'b1;
                    open_start_next = char_t'(pos_reg);
                    if (count_reg != 2'd2)
                        count_next = count_reg + 2'd1;
                    if (count_next == 2'd2 && held_valid_reg)
                    begin
                        push.items[push.count] = '{sos_pkg::KIND_SEG, '0, held_len_reg, 1'b0};
                        push.count = push.count + 2'd1;
                        held_valid_next = 1'b0;
                    end
                end

                // separator completed: close the open segment
                if (csm_next >= eff_len && win_match)
                begin
                    match_len = char_t'(pos_reg) + char_t'(1) - char_t'(eff_len)
                                - open_start_next;
                    if (count_next == 2'd1)
                    begin
                        held_len_next   = match_len;
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        push.items[push.count] = '{sos_pkg::KIND_SEG, open_start_next,
                                                   match_len, 1'b0};
                        push.count = push.count + 2'd1;
                    end
                    seg_open_next = 1'b0;
                    csm_next      = 3'd0;
                end
                pos_next = pos_reg + PW'(1);
            end

            // end of string: status, then back to the reset state
            if (eos_reg)
            begin
                if (pos_next > LEN_LIMIT)
                begin
                    push.items[push.count] = '{sos_pkg::KIND_TOOLONG, '0, '0, 1'b1};
                    push.count = push.count + 2'd1;
                end
                else if (count_next != 2'd2)
                begin
                    push.items[push.count] = '{sos_pkg::KIND_NOSPLIT, '0, '0, 1'b1};
                    push.count = push.count + 2'd1;
                end
                else
                begin
                    if (seg_open_next)
                    begin
                        push.items[push.count] = '{sos_pkg::KIND_SEG, open_start_next,
                                                   char_t'(pos_next) - open_start_next, 1'b0};
                        push.count = push.count + 2'd1;
                    end
                    push.items[push.count] = '{sos_pkg::KIND_DONE, '0, '0, 1'b1};
                    push.count = push.count + 2'd1;
                end
                window_next     = '0;
                csm_next        = 3'd0;
                pos_next        = '0;
                open_start_next = '0;
                seg_open_next   = 1'b0;
                count_next      = 2'd0;
                held_len_next   = '0;
                held_valid_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            csm_reg        <= 3'd0;
            pos_reg        <= '0;
            open_start_reg <= '0;
            seg_open_reg   <= 1'b0;
            count_reg      <= 2'd0;
            held_len_reg   <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg     <= window_next;
            csm_reg        <= csm_next;
            pos_reg        <= pos_next;
            open_start_reg <= open_start_next;
            seg_open_reg   <= seg_open_next;
            count_reg      <= count_next;
            held_len_reg   <= held_len_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sos_queue.sv]
// Result queue: takes up to three results a cycle, hands out one unless head_stall is high.
`default_nettype none

module sos_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sos_pkg::push_t push,
    output logic             space_ok,
    output logic             head_valid,
    input  wire logic        head_stall,
    output sos_pkg::result_t head
);

    localparam int PTR_W = $clog2(sos_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sos_pkg::QUEUE_DEPTH + 1);

    sos_pkg::result_t mem [sos_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    // Handshake and room for two more requests' worth of results
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && !head_stall;
    assign space_ok   = (count_reg <= CNT_W'(sos_pkg::ACCEPT_LEVEL));
    assign head       = mem[rd_ptr_reg];

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: consecutive slots from the write pointer
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < sos_pkg::PUSH_MAX; k++)
        begin
            if (2'(k) < push.count)
                mem[wr_ptr_reg + PTR_W'(k)] <= push.items[k];
        end
    end

endmodule

`default_nettype wire

[rtl/core/split_on_separator.sv]
// Top level of the separator splitter: configuration registers, core and result queue.
//
// Splits a stream of 16-bit characters on a separator of one to four characters.
// One request is taken per cycle while in_stall is low; its results pass the
// request register and then an eight-entry result queue, which hands them out one
// per cycle while out_stall is low. A request can yield up to three results, so
// in_stall rises while the queue holds more than two results; with out_stall low
// and at most one result per request the block sustains one request per clock.
// Configuration is written through cfg_valid/cfg_ready (always ready); the user
// must write it only while no request is in flight, as the block does not check.
`default_nettype none

module split_on_separator #(
    parameter int MAX_SEP = 4,
    parameter int MAX_LEN = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sos_pkg::CHAR_W-1:0]    ch,
    input  wire logic                          has_char,
    input  wire logic                          end_of_string,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         kind,
    output logic [sos_pkg::CHAR_W-1:0]         seg_start,
    output logic [sos_pkg::CHAR_W-1:0]         seg_length,
    output logic                               last,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [4*sos_pkg::CHAR_W-1:0]  cfg_data
);

    logic [2:0]                   sep_len_reg;
    logic [4*sos_pkg::CHAR_W-1:0] sep_chars_reg;

    logic             accept;
    logic             space_ok;
    sos_pkg::push_t   push;
    sos_pkg::result_t head;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_len_reg   <= 3'd1;
            sep_chars_reg <= 64'd44;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sos_pkg::cfg_reg_t'(cfg_index))
                sos_pkg::REG_SEP_LEN:   sep_len_reg   <= cfg_data[2:0];
                sos_pkg::REG_SEP_CHARS: sep_chars_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Input handshake
    assign in_stall = !space_ok;
    assign accept   = in_valid && !in_stall;

    sos_core #(
        .MAX_SEP (MAX_SEP),
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ch            (ch),
        .has_char      (has_char),
        .end_of_string (end_of_string),
        .sep_len       (sep_len_reg),
        .sep_chars     (sep_chars_reg),
        .push          (push)
    );

    sos_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (out_valid),
        .head_stall (out_stall),
        .head       (head)
    );

    // Result fields
    assign kind       = head.kind;
    assign seg_start  = head.start;
    assign seg_length = head.length;
    assign last       = head.last;

endmodule

`default_nettype wire
